// File: rtl/smstep_pkg.sv
`default_nettype none
package smstep_pkg;

    // program counter width: holds any 16-bit jump target plus one increment
    localparam int PC_W = 17;

    // input commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // opcodes
    localparam logic [3:0] OP_LOAD_CONST = 4'd0;
    localparam logic [3:0] OP_PRINT      = 4'd1;
    localparam logic [3:0] OP_EXIT       = 4'd2;
    localparam logic [3:0] OP_POP        = 4'd3;
    localparam logic [3:0] OP_ADD        = 4'd4;
    localparam logic [3:0] OP_DIV        = 4'd5;
    localparam logic [3:0] OP_EQ         = 4'd6;
    localparam logic [3:0] OP_NEQ        = 4'd7;
    localparam logic [3:0] OP_DUP        = 4'd8;
    localparam logic [3:0] OP_JMP        = 4'd9;
    localparam logic [3:0] OP_JMPZ       = 4'd10;
    localparam logic [3:0] OP_WRITE      = 4'd11;
    localparam logic [3:0] OP_WRITE_CHAR = 4'd12;

    // result status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALTED  = 3'd1;
    localparam logic [2:0] ST_UNDER   = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_BADPC   = 3'd4;
    localparam logic [2:0] ST_OVER    = 3'd5;
    localparam logic [2:0] ST_BADOP   = 3'd6;
    localparam logic [2:0] ST_NOTRUN  = 3'd7;

    // emitted value kind
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PRINT = 2'd1;
    localparam logic [1:0] KIND_DEC   = 2'd2;
    localparam logic [1:0] KIND_CHAR  = 2'd3;

    // machine run mode
    localparam logic [1:0] MODE_RUN   = 2'd0;
    localparam logic [1:0] MODE_HALT  = 2'd1;
    localparam logic [1:0] MODE_FAULT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ1,
        S_READ2,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;     // capture input transaction
        logic decode;     // run command, issue fetch and top read
        logic rd_top;     // capture program word and top, issue second read
        logic rd_sec;     // capture second item
        logic commit;     // update machine state from the execute result
        logic div_start;  // launch the divider
        logic emit;       // load the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_fetch;   // step command may fetch
        logic div_go;     // instruction needs the divider
        logic div_done;   // quotient ready
        logic out_free;   // output register can take a result
    } t_ctrl_sts;

endpackage
`default_nettype wire

// File: rtl/smstep_ram.sv
`default_nettype none
module smstep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/smstep_div.sv
`default_nettype none
module smstep_div #(
    parameter int W = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire  [W-1:0] i_num,
    input  wire  [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W:0]       r_rem;
    logic [W-1:0]     r_quo, r_den;
    logic             r_neg;
    logic [W:0]       rem_sh, diff;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem[W-1:0], r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // load magnitudes on start, then iterate one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[W-1] ? (~i_num + W'(1)) : i_num;
            r_den <= i_den[W-1] ? (~i_den + W'(1)) : i_den;
            r_neg <= i_num[W-1] ^ i_den[W-1];
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (~r_quo + W'(1)) : r_quo;

endmodule
`default_nettype wire

// File: rtl/smstep_ctrl.sv
`default_nettype none
module smstep_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  smstep_pkg::t_ctrl_sts  i_sts,
    output smstep_pkg::t_ctrl_cmd  o_cmd
);

    smstep_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smstep_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smstep_pkg::S_IDLE:   if (i_in_valid) n_state = smstep_pkg::S_DECODE;
            smstep_pkg::S_DECODE: begin
                n_state = i_sts.go_fetch ? smstep_pkg::S_READ1 : smstep_pkg::S_DONE;
            end
            smstep_pkg::S_READ1:  n_state = smstep_pkg::S_READ2;
            smstep_pkg::S_READ2:  n_state = smstep_pkg::S_EXEC;
            smstep_pkg::S_EXEC: begin
                n_state = i_sts.div_go ? smstep_pkg::S_DIV : smstep_pkg::S_DONE;
            end
            smstep_pkg::S_DIV:    if (i_sts.div_done) n_state = smstep_pkg::S_DONE;
            smstep_pkg::S_DONE:   if (i_sts.out_free) n_state = smstep_pkg::S_IDLE;
            default:              n_state = smstep_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            smstep_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            smstep_pkg::S_DECODE: o_cmd.decode = 1'b1;
            smstep_pkg::S_READ1:  o_cmd.rd_top = 1'b1;
            smstep_pkg::S_READ2:  o_cmd.rd_sec = 1'b1;
            smstep_pkg::S_EXEC: begin
                o_cmd.commit    = !i_sts.div_go;
                o_cmd.div_start = i_sts.div_go;
            end
            smstep_pkg::S_DIV:    o_cmd.commit = i_sts.div_done;
            smstep_pkg::S_DONE:   o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/smstep_dp.sv
`default_nettype none
module smstep_dp #(
    parameter int PROG_DEPTH  = 1024,
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  smstep_pkg::t_ctrl_cmd  i_cmd,
    output smstep_pkg::t_ctrl_sts  o_sts,
    input  wire  [1:0]             i_in_cmd,
    input  wire  [9:0]             i_in_addr,
    input  wire  [3:0]             i_in_op,
    input  wire  [63:0]            i_in_arg,
    input  wire                    i_cfg_we,
    input  wire  [10:0]            i_cfg_len,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic [2:0]             o_out_status,
    output logic [1:0]             o_out_kind,
    output logic [63:0]            o_out_value,
    output logic [9:0]             o_out_pc
);

    localparam int DW   = DATA_WIDTH;
    localparam int PCW  = smstep_pkg::PC_W;
    localparam int PAW  = $clog2(PROG_DEPTH);
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int CW   = $clog2(STACK_DEPTH + 1);

    // machine state
    logic [PCW-1:0] r_pc;
    logic [CW-1:0]  r_cnt;
    logic           r_inv;
    logic [1:0]     r_mode;
    logic [10:0]    r_len;

    // captured transaction and operands
    logic [1:0]     r_in_cmd;
    logic [9:0]     r_in_addr;
    logic [3:0]     r_in_op;
    logic [DW-1:0]  r_in_arg;
    logic [3:0]     r_op;
    logic [DW-1:0]  r_arg, r_top, r_sec;

    // result
    logic [2:0]     r_st;
    logic [1:0]     r_kind;
    logic [DW-1:0]  r_val;

    // memories
    logic [PCW-1:0]   addr_ext;
    logic             prog_we;
    logic [DW+3:0]    prog_q;
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr, stk_raddr;
    logic [DW-1:0]    stk_wdata, stk_q;

    logic           fetch_ok;
    logic           div_done;
    logic [DW-1:0]  div_q;

    // execute results
    logic [2:0]     x_st;
    logic [1:0]     x_kind;
    logic [DW-1:0]  x_val, x_sec;
    logic [CW-1:0]  x_cnt;
    logic [PCW-1:0] x_pc;
    logic           x_inv, x_push, x_bin;
    logic           has1, has2, full;
    logic [63:0]    arg64;

    assign addr_ext = PCW'(r_in_addr);
    assign prog_we  = i_cmd.decode && (r_in_cmd == smstep_pkg::CMD_WRITE)
                      && (addr_ext < PCW'(PROG_DEPTH));
    assign fetch_ok = (r_mode == smstep_pkg::MODE_RUN) && !r_inv
                      && (r_pc < PCW'(r_len)) && (r_pc < PCW'(PROG_DEPTH));

    smstep_ram #(.WIDTH(DW + 4), .DEPTH(PROG_DEPTH)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (addr_ext[PAW-1:0]),
        .i_wdata ({r_in_op, r_in_arg}),
        .i_raddr (r_pc[PAW-1:0]),
        .o_rdata (prog_q)
    );

    // top is read during decode, second item during the next cycle
    assign stk_raddr = i_cmd.decode ? SAW'(r_cnt - CW'(1)) : SAW'(r_cnt - CW'(2));

    smstep_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    smstep_div #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_sec),
        .i_den   (r_top),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // execute one instruction on the captured operands
    always_comb begin
        has1   = r_cnt != '0;
        has2   = r_cnt >= CW'(2);
        full   = r_cnt >= CW'(STACK_DEPTH);
        arg64  = 64'($signed(r_arg));
        x_st   = smstep_pkg::ST_OK;
        x_kind = smstep_pkg::KIND_NONE;
        x_val  = '0;
        x_sec  = '0;
        x_cnt  = r_cnt;
        x_pc   = r_pc + PCW'(1);
        x_inv  = 1'b0;
        x_push = 1'b0;
        x_bin  = 1'b0;
        case (r_op) inside
            smstep_pkg::OP_LOAD_CONST, smstep_pkg::OP_DUP: begin
                if (r_op == smstep_pkg::OP_DUP && !has1) begin
                    x_st = smstep_pkg::ST_UNDER;
                end else if (full) begin
                    x_st = smstep_pkg::ST_OVER;
                end else begin
                    x_push = 1'b1;
                    x_cnt  = r_cnt + CW'(1);
                end
            end
            smstep_pkg::OP_PRINT, smstep_pkg::OP_WRITE, smstep_pkg::OP_WRITE_CHAR: begin
                if (!has1) begin
                    x_st = smstep_pkg::ST_UNDER;
                end else if (r_op == smstep_pkg::OP_PRINT) begin
                    x_kind = smstep_pkg::KIND_PRINT;
                    x_val  = r_top;
                end else if (r_op == smstep_pkg::OP_WRITE) begin
                    x_kind = smstep_pkg::KIND_DEC;
                    x_val  = r_top;
                end else begin
                    x_kind = smstep_pkg::KIND_CHAR;
                    x_val  = DW'(r_top[7:0]);
                end
            end
            smstep_pkg::OP_EXIT: begin
                if (!has1) begin
                    x_st = smstep_pkg::ST_UNDER;
                end else begin
                    x_st  = smstep_pkg::ST_HALTED;
                    x_val = r_top;
                end
            end
            smstep_pkg::OP_POP: begin
                if (!has1) x_st = smstep_pkg::ST_UNDER;
                else       x_cnt = r_cnt - CW'(1);
            end
            smstep_pkg::OP_ADD, smstep_pkg::OP_DIV, smstep_pkg::OP_EQ, smstep_pkg::OP_NEQ: begin
                if (!has2) begin
                    x_st = smstep_pkg::ST_UNDER;
                end else if (r_op == smstep_pkg::OP_DIV && r_top == '0) begin
                    x_st = smstep_pkg::ST_DIVZERO;
                end else begin
                    x_bin = 1'b1;
                    x_cnt = r_cnt - CW'(1);
                    case (r_op)
                        smstep_pkg::OP_ADD: x_sec = r_sec + r_top;
                        smstep_pkg::OP_DIV: x_sec = div_q;
                        smstep_pkg::OP_EQ:  x_sec = DW'(r_sec == r_top);
                        default:            x_sec = DW'(r_sec != r_top);
                    endcase
                end
            end
            smstep_pkg::OP_JMP, smstep_pkg::OP_JMPZ: begin
                if (r_op == smstep_pkg::OP_JMPZ && !has1) begin
                    x_st = smstep_pkg::ST_UNDER;
                end else begin
                    if (r_op == smstep_pkg::OP_JMPZ) x_cnt = r_cnt - CW'(1);
                    if (r_op == smstep_pkg::OP_JMP || r_top == '0) begin
                        x_inv = arg64 >= 64'(PROG_DEPTH);
                        x_pc  = PCW'(arg64[15:0]);
                    end
                end
            end
            default: x_st = smstep_pkg::ST_BADOP;
        endcase
    end

    assign stk_we    = i_cmd.commit && (x_push || x_bin);
    assign stk_waddr = x_push ? SAW'(r_cnt) : SAW'(r_cnt - CW'(2));
    assign stk_wdata = x_push ? ((r_op == smstep_pkg::OP_LOAD_CONST) ? r_arg : r_top) : x_sec;

    // control state: mode, counters, length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_cnt  <= '0;
            r_inv  <= 1'b0;
            r_mode <= smstep_pkg::MODE_RUN;
            r_len  <= 11'd1;
        end else begin
            if (i_cfg_we) r_len <= i_cfg_len;
            if (i_cmd.decode) begin
                if (r_in_cmd == smstep_pkg::CMD_RESTART) begin
                    r_pc   <= '0;
                    r_cnt  <= '0;
                    r_inv  <= 1'b0;
                    r_mode <= smstep_pkg::MODE_RUN;
                end else if (r_in_cmd == smstep_pkg::CMD_STEP
                             && r_mode == smstep_pkg::MODE_RUN && !fetch_ok) begin
                    r_mode <= smstep_pkg::MODE_FAULT;
                end
            end
            if (i_cmd.commit) begin
                if (x_st == smstep_pkg::ST_OK || x_st == smstep_pkg::ST_HALTED) begin
                    r_cnt <= x_cnt;
                    r_pc  <= x_pc;
                    r_inv <= x_inv;
                    if (x_st == smstep_pkg::ST_HALTED) r_mode <= smstep_pkg::MODE_HALT;
                end else begin
                    r_mode <= smstep_pkg::MODE_FAULT;
                end
            end
        end
    end

    // capture transaction, operands and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_cmd  <= i_in_cmd;
            r_in_addr <= i_in_addr;
            r_in_op   <= i_in_op;
            r_in_arg  <= i_in_arg[DW-1:0];
        end
        if (i_cmd.decode) begin
            r_st   <= smstep_pkg::ST_OK;
            r_kind <= smstep_pkg::KIND_NONE;
            r_val  <= '0;
            if (r_in_cmd == smstep_pkg::CMD_STEP) begin
                if (r_mode != smstep_pkg::MODE_RUN) r_st <= smstep_pkg::ST_NOTRUN;
                else if (!fetch_ok)                 r_st <= smstep_pkg::ST_BADPC;
            end
        end
        if (i_cmd.rd_top) begin
            r_op  <= prog_q[DW+3:DW];
            r_arg <= prog_q[DW-1:0];
            r_top <= (r_cnt != '0) ? stk_q : '0;
        end
        if (i_cmd.rd_sec) begin
            r_sec <= (r_cnt >= CW'(2)) ? stk_q : '0;
        end
        if (i_cmd.commit) begin
            r_st   <= x_st;
            r_kind <= x_kind;
            r_val  <= x_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_status <= r_st;
            o_out_kind   <= r_kind;
            o_out_value  <= 64'($signed(r_val));
            o_out_pc     <= r_pc[9:0];
        end
    end

    assign o_sts.go_fetch = (r_in_cmd == smstep_pkg::CMD_STEP) && fetch_ok;
    assign o_sts.div_go   = (r_op == smstep_pkg::OP_DIV) && has2 && (r_top != '0);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

// File: rtl/stack_machine_step.sv
// Channel  Dir  Handshake               Payload
// s_axis   in   s_axis_tvalid/tready    tuser: cmd; tdata: prog_addr, opcode, argument
// m_axis   out  m_axis_tvalid/tready    tuser: out_kind; tdata: status, out_value, next_pc
// cfg      in   i_cfg_wr_en             i_cfg_wr_data: program_length
//
// A write, restart or refused step goes from accept through decode to the result state; an
// executed step also passes the read states and execute, set by the registered program and
// stack memory reads (top, then second).
// DIV also waits on the bit-serial divider.
// Reset (synchronous, active low) empties the stack, clears pc and sets the machine running.
// The output register holds a result until taken; the next input waits for that slot.
`default_nettype none
module stack_machine_step #(
    parameter int PROG_DEPTH  = 1024,
    parameter int STACK_DEPTH = 256,
    parameter int DATA_WIDTH  = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [79:0] s_axis_tdata,   // prog_addr[9:0], opcode[13:10], argument[77:14], 0
    input  wire  [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status[2:0], out_value[66:3], next_pc[76:67], 0
    output logic [1:0]  m_axis_tuser,   // out_kind
    input  wire         i_cfg_wr_en,
    input  wire  [10:0] i_cfg_wr_data
);

    smstep_pkg::t_ctrl_cmd cmd;
    smstep_pkg::t_ctrl_sts sts;
    logic [2:0]  out_status;
    logic [63:0] out_value;
    logic [9:0]  out_pc;

    smstep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smstep_dp #(
        .PROG_DEPTH  (PROG_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_cmd     (s_axis_tuser),
        .i_in_addr    (s_axis_tdata[9:0]),
        .i_in_op      (s_axis_tdata[13:10]),
        .i_in_arg     (s_axis_tdata[77:14]),
        .i_cfg_we     (i_cfg_wr_en),
        .i_cfg_len    (i_cfg_wr_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (out_status),
        .o_out_kind   (m_axis_tuser),
        .o_out_value  (out_value),
        .o_out_pc     (out_pc)
    );

    // pack result fields
    assign m_axis_tdata = {3'b000, out_pc, out_value, out_status};

endmodule
`default_nettype wire
